### design/hhr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhr_pkg
// shared types and codes for the hitbox history rewind block
// ----------------------------------------------------------------------------
package hhr_pkg;

  // samples kept per track; ring pointers wrap by truncation, so a power of two
  localparam int HISTORY_DEPTH = 16;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_REWIND = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        r;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_FIRST,
    ST_LAST,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_DIV,
    ST_LERP,
    ST_DONE
  } state_t;

endpackage

### design/hhr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhr_div
// restoring divider, one quotient bit per cycle, 48-bit dividend / 33-bit span
// ----------------------------------------------------------------------------
module hhr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [16:0] quot
);
  logic [47:0] num_r, num_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[32:0], num_r[47]};
    if (go) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[46:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign quot = q_nxt[16:0];
endmodule

### design/hhr_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhr_lerp
// registered a + floor((b - a) * frac / 65536), floor toward minus infinity
// ----------------------------------------------------------------------------
module hhr_lerp (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [24:0] b,
  input  logic [16:0]        frac,
  output logic signed [24:0] res
);
  logic signed [25:0] diff;
  logic signed [43:0] prod_r;
  logic signed [24:0] a_r;
  logic signed [43:0] q;

  assign diff = 26'(b) - 26'(a);
  assign q    = prod_r >>> 16;

  always_ff @(posedge clk) begin
    prod_r <= 44'(diff) * $signed({27'd0, frac});
    a_r    <= a;
  end

  assign res = 25'(44'(a_r) + q);
endmodule

### design/hitbox_history_rewind.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hitbox_history_rewind
// per-track timestamped sample ring with record, clear and rewind
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and exactly one
// result appears later on out_valid for a single cycle; the receiver cannot
// stall it. After reset busy stays high while the track table is cleared. A bad
// track or unused opcode goes straight to the result; record and clear read
// and write the track metadata; a rewind that fails its checks ends after the
// metadata check, and a clamped rewind after reading the oldest and newest
// samples. An interpolated rewind then reads the ring one entry at a time
// through the single sample memory port, waits for the divider that forms the
// Q1.16 fraction, then for the interpolation multipliers, and presents the
// result.
module hitbox_history_rewind #(
  parameter int TRACK_COUNT   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_track_id,
  input  logic [31:0]        in_sample_time,
  input  logic [31:0]        in_now_time,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_size_r,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic               out_ok,
  output logic [31:0]        out_time,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y,
  output logic signed [23:0] out_z,
  output logic [15:0]        out_r
);
  import hhr_pkg::*;

  localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int MW = 1 + HW + CW;
  localparam int AW = TW + HW;

  // track metadata memory: active, write pointer, fill count
  logic [MW-1:0] meta_mem [TRACK_COUNT];
  logic [MW-1:0] meta_rd_r;
  logic          meta_we;
  logic [MW-1:0] meta_wd;
  // sample memory
  sample_t       smem [TRACK_COUNT*HISTORY_DEPTH];
  sample_t       s_rd_r;
  logic          s_we;
  logic [AW-1:0] s_addr;

  // clearing pass over the metadata after reset
  logic [TW:0]   clr_r, clr_nxt;
  logic          clearing;
  assign clearing = (clr_r != TW'(0) + (TW+1)'(TRACK_COUNT));

  state_t state_r, state_nxt;
  logic [31:0] limit_r;
  logic [1:0]  op_r;
  logic [TW-1:0] trk_r;
  logic [31:0] st_r, now_r;
  sample_t     in_s_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0] old_r, old_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  sample_t     a_r, a_nxt, b_r, b_nxt;
  logic        ok_r, ok_nxt;
  sample_t     res_r, res_nxt;
  logic        div_go, div_done;
  logic [16:0] div_q, frac_r, frac_nxt;
  logic [1:0]  lw_r, lw_nxt;
  logic [HW-1:0] rd_idx;
  logic signed [24:0] lx, ly, lz, lr;
  logic        bad_trk;

  assign busy = (state_r != ST_IDLE) || clearing;

  // out of range track, answered at once with ok low
  assign bad_trk = ({1'b0, in_track_id} >= 9'(TRACK_COUNT));

  // metadata read/write
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[clearing ? clr_r[TW-1:0] : trk_r] <= meta_wd;
    meta_rd_r <= meta_mem[trk_r];
  end

  // sample memory: one port, write or read
  always_ff @(posedge clk) begin
    if (s_we) smem[s_addr] <= in_s_r;
    s_rd_r <= smem[s_addr];
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    old_nxt   = old_r;
    idx_nxt   = idx_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ok_nxt    = ok_r;
    res_nxt   = res_r;
    frac_nxt  = frac_r;
    lw_nxt    = lw_r;
    meta_we   = 1'b0;
    meta_wd   = '0;
    s_we      = 1'b0;
    div_go    = 1'b0;
    rd_idx    = HW'(old_r + idx_r[HW-1:0]);
    s_addr    = {trk_r, rd_idx};
    if (clearing) begin
      meta_we = 1'b1;
      clr_nxt = clr_r + (TW+1)'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (start && !clearing) begin
          if (bad_trk || in_opcode == OP_UNUSED) state_nxt = ST_DONE;
          else state_nxt = ST_META;
        end
      end
      ST_META: begin
        // meta_rd_r valid next cycle
        ok_nxt  = 1'b0;
        res_nxt = '0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_nxt = meta_rd_r[CW-1:0];
        unique case (op_r)
          OP_RECORD: begin
            s_we   = 1'b1;
            s_addr = {trk_r, meta_rd_r[CW +: HW]};
            meta_we = 1'b1;
            meta_wd = {1'b1, HW'(meta_rd_r[CW +: HW] + HW'(1)),
                       (meta_rd_r[CW-1:0] < CW'(HISTORY_DEPTH)) ?
                         CW'(meta_rd_r[CW-1:0] + CW'(1)) : meta_rd_r[CW-1:0]};
            ok_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end
          OP_CLEAR: begin
            meta_we = 1'b1;
            meta_wd = '0;
            ok_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            if (!meta_rd_r[MW-1] || meta_rd_r[CW-1:0] < CW'(2) ||
                ($signed({1'b0, now_r}) - $signed({1'b0, st_r})) >
                $signed({1'b0, limit_r})) begin
              state_nxt = ST_DONE;
            end else begin
              old_nxt = HW'({1'b0, meta_rd_r[CW +: HW]} + (HW+1)'(HISTORY_DEPTH)
                            - (HW+1)'(meta_rd_r[CW-1:0]));
              idx_nxt = '0;
              state_nxt = ST_FIRST;
            end
          end
        endcase
      end
      ST_FIRST: begin
        // address oldest, data next cycle
        idx_nxt = CW'(cnt_r - CW'(1));
        state_nxt = ST_LAST;
      end
      ST_LAST: begin
        a_nxt = s_rd_r;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        b_nxt = s_rd_r;
        if (st_r <= a_r.t) begin
          ok_nxt = 1'b1; res_nxt = a_r; state_nxt = ST_DONE;
        end else if (st_r >= s_rd_r.t) begin
          ok_nxt = 1'b1; res_nxt = s_rd_r; state_nxt = ST_DONE;
        end else begin
          idx_nxt = CW'(1);
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        // a_r holds entry idx-1; s_rd_r holds entry idx once lw_r is set
        if (lw_r == 2'd0) begin
          lw_nxt = 2'd1;
        end else begin
          lw_nxt = 2'd0;
          b_nxt  = s_rd_r;
          if (st_r >= a_r.t && st_r <= s_rd_r.t) begin
            state_nxt = ST_DIV;
            div_go    = 1'b1;
          end else if (idx_r == CW'(cnt_r - CW'(1))) begin
            state_nxt = ST_DONE;
          end else begin
            a_nxt   = s_rd_r;
            idx_nxt = CW'(idx_r + CW'(1));
          end
        end
      end
      ST_DIV: begin
        if (b_r.t == a_r.t) begin
          frac_nxt = '0;
          lw_nxt = 2'd0;
          state_nxt = ST_LERP;
        end else if (div_done) begin
          frac_nxt = div_q;
          lw_nxt = 2'd0;
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        lw_nxt = lw_r + 2'd1;
        if (lw_r == 2'd2) begin
          ok_nxt = 1'b1;
          res_nxt.t = st_r;
          res_nxt.x = lx[23:0];
          res_nxt.y = ly[23:0];
          res_nxt.z = lz[23:0];
          res_nxt.r = lr[15:0];
          lw_nxt = 2'd0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  hhr_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .dividend({st_r - a_r.t, 16'd0}),
    .divisor({1'b0, b_r.t - a_r.t}),
    .done(div_done), .quot(div_q)
  );

  hhr_lerp u_lx (.clk(clk), .a(25'(a_r.x)), .b(25'(b_r.x)), .frac(frac_r), .res(lx));
  hhr_lerp u_ly (.clk(clk), .a(25'(a_r.y)), .b(25'(b_r.y)), .frac(frac_r), .res(ly));
  hhr_lerp u_lz (.clk(clk), .a(25'(a_r.z)), .b(25'(b_r.z)), .frac(frac_r), .res(lz));
  hhr_lerp u_lr (.clk(clk), .a($signed({9'd0, a_r.r})), .b($signed({9'd0, b_r.r})),
                 .frac(frac_r), .res(lr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_r   <= '0;
      limit_r <= 32'hFFFF_FFFF;
      lw_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      lw_r  <= lw_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      out_valid <= (state_r == ST_DONE);
    end
    if (state_r == ST_IDLE) begin
      op_r   <= in_opcode;
      trk_r  <= TW'(in_track_id);
      st_r   <= in_sample_time;
      now_r  <= in_now_time;
      in_s_r <= '{t: in_sample_time, x: in_pos_x, y: in_pos_y, z: in_pos_z, r: in_size_r};
      ok_r   <= 1'b0;
      res_r  <= '0;
    end else begin
      ok_r  <= ok_nxt;
      res_r <= res_nxt;
    end
    cnt_r  <= cnt_nxt;
    old_r  <= old_nxt;
    idx_r  <= idx_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    frac_r <= frac_nxt;
    out_ok   <= ok_r;
    out_time <= res_r.t;
    out_x    <= res_r.x;
    out_y    <= res_r.y;
    out_z    <= res_r.z;
    out_r    <= res_r.r;
  end
endmodule
